>>> rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, constants and helpers of the LED strip fade and frame driver.
// ----------------------------------------------------------------------------
package lsf_pkg;

	// Fixed field widths
	localparam int IdxW   = 6;
	localparam int ChanW  = 8;
	localparam int WordW  = 24;
	localparam int CountW = 5;
	localparam int CfgIdxW = 1;

	// Frame word sizes
	localparam logic [CountW-1:0] HdrBits   = 5'd24;
	localparam logic [CountW-1:0] PixBits   = 5'd24;
	localparam logic [CountW-1:0] TrailBits = 5'd16;

	// Strip protocol keeps bit 7 of every colour byte set
	localparam logic [ChanW-1:0] MarkBit = 8'h80;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegDim  = 1'b0;
	localparam logic [CfgIdxW-1:0] RegStep = 1'b1;

	// Command queue between front and back
	localparam int QueueDepth = 2;
	localparam int QPtrW      = 1;
	localparam int QCntW      = 2;

	// Restoring divider: one quotient bit per cycle
	localparam int DivSteps = 8;
	localparam int DivCntW  = 4;

	typedef enum logic [1:0] {
		OP_TARGET = 2'd0,
		OP_TICK   = 2'd1,
		OP_PIXEL  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_t;

	typedef struct packed {
		op_t             op;
		logic [IdxW-1:0] idx;
		rgb_t            colour;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FADE,
		ST_HDR,
		ST_PIX,
		ST_TRL
	} back_state_t;

	// Build the G-R-B strip word with the mark bit forced on
	function automatic logic [WordW-1:0] pack_grb(input rgb_t c);
		return {c.green | MarkBit, c.red | MarkBit, c.blue | MarkBit};
	endfunction

endpackage

>>> rtl/lsf_ram.sv
// ----------------------------------------------------------------------------
// lsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsf_ram #(
	parameter int Width = 24,
	parameter int Depth = 48,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lsf_front.sv
// ----------------------------------------------------------------------------
// lsf_front
// Command intake: decodes func, drops out-of-range pixel writes and queues
// the rest for the back end.
// ----------------------------------------------------------------------------
module lsf_front #(
	parameter int PIXEL_COUNT = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 func,
	input  logic [lsf_pkg::IdxW-1:0]   pixel_index,
	input  logic [lsf_pkg::ChanW-1:0]  red,
	input  logic [lsf_pkg::ChanW-1:0]  green,
	input  logic [lsf_pkg::ChanW-1:0]  blue,
	output logic                       busy,
	output lsf_pkg::cmd_t              head,
	output logic                       head_valid,
	input  logic                       pop
);

	lsf_pkg::cmd_t                 queue_q [lsf_pkg::QueueDepth];
	logic [lsf_pkg::QPtrW-1:0]     wr_ptr_q;
	logic [lsf_pkg::QPtrW-1:0]     rd_ptr_q;
	logic [lsf_pkg::QCntW-1:0]     count_q;
	lsf_pkg::cmd_t                 cmd;
	logic                          keep;
	logic                          push;

	// Classify the incoming transaction
	always_comb begin
		cmd.op     = lsf_pkg::op_t'(func);
		cmd.idx    = pixel_index;
		cmd.colour = '{red: red, green: green, blue: blue};
		keep = (cmd.op != lsf_pkg::OP_PIXEL) ||
			({1'b0, pixel_index} < (lsf_pkg::IdxW + 1)'(PIXEL_COUNT));
	end

	assign busy       = (count_q == lsf_pkg::QCntW'(lsf_pkg::QueueDepth));
	assign push       = start && !busy && keep;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	// Store queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/lsf_div.sv
// ----------------------------------------------------------------------------
// lsf_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module lsf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  lsf_pkg::rgb_t             num,
	input  logic [lsf_pkg::ChanW-1:0] den,
	output logic                      done,
	output lsf_pkg::rgb_t             quo
);

	logic [2:0][lsf_pkg::ChanW-1:0] shf_q;
	logic [2:0][lsf_pkg::ChanW-1:0] rem_q;
	logic [2:0][lsf_pkg::ChanW-1:0] shf_nx;
	logic [2:0][lsf_pkg::ChanW-1:0] rem_nx;
	logic [2:0][lsf_pkg::ChanW:0]   trial;
	logic [lsf_pkg::DivCntW-1:0]    cnt_q;
	logic                           run_q;
	logic                           done_q;

	// One restoring step per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], shf_q[i][lsf_pkg::ChanW-1]};
			if (trial[i] >= {1'b0, den}) begin
				rem_nx[i] = lsf_pkg::ChanW'(trial[i] - {1'b0, den});
				shf_nx[i] = {shf_q[i][lsf_pkg::ChanW-2:0], 1'b1};
			end else begin
				rem_nx[i] = trial[i][lsf_pkg::ChanW-1:0];
				shf_nx[i] = {shf_q[i][lsf_pkg::ChanW-2:0], 1'b0};
			end
		end
	end

	// Load operands or shift in the next quotient bit
	always_ff @(posedge clk) begin
		if (go) begin
			shf_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			shf_q <= shf_nx;
			rem_q <= rem_nx;
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lsf_pkg::DivCntW'(lsf_pkg::DivSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = lsf_pkg::rgb_t'(shf_q);

endmodule

>>> rtl/lsf_back.sv
// ----------------------------------------------------------------------------
// lsf_back
// Command execution: target division, fade, pixel store and frame output.
// ----------------------------------------------------------------------------
module lsf_back #(
	parameter int PIXEL_COUNT = 48,
	localparam int AddrW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsf_pkg::cmd_t               head,
	input  logic                        head_valid,
	output logic                        pop,
	input  logic [lsf_pkg::ChanW-1:0]   dim_divisor,
	input  logic [lsf_pkg::ChanW-1:0]   fade_step,
	output logic                        word_strobe,
	output logic [lsf_pkg::WordW-1:0]   shift_word,
	output logic [lsf_pkg::CountW-1:0]  bit_count,
	output logic                        frame_last
);

	lsf_pkg::back_state_t         state_q;
	lsf_pkg::back_state_t         state_nx;
	logic [AddrW-1:0]             cnt_q;
	lsf_pkg::rgb_t                target_q;
	lsf_pkg::rgb_t                current_q;
	lsf_pkg::rgb_t                faded;
	logic [lsf_pkg::WordW-1:0]    fill_q;
	logic [PIXEL_COUNT-1:0]       valid_q;
	logic                         vsel_s1;
	logic                         pix_last;
	logic                         div_go;
	logic                         div_done;
	lsf_pkg::rgb_t                div_quo;
	logic                         mem_we;
	logic [AddrW-1:0]             waddr;
	logic [AddrW-1:0]             raddr;
	logic [lsf_pkg::WordW-1:0]    rdata;
	logic                         word_strobe_q;
	logic [lsf_pkg::WordW-1:0]    shift_word_q;
	logic [lsf_pkg::CountW-1:0]   bit_count_q;
	logic                         frame_last_q;

	// Move one channel toward its target without passing it
	function automatic logic [lsf_pkg::ChanW-1:0] fade_chan(
		input logic [lsf_pkg::ChanW-1:0] cur,
		input logic [lsf_pkg::ChanW-1:0] tgt,
		input logic [lsf_pkg::ChanW-1:0] step
	);
		logic [lsf_pkg::ChanW-1:0] gap;
		gap = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
		if (step == '0 || gap < step) begin
			return tgt;
		end else if (tgt > cur) begin
			return cur + step;
		end else begin
			return cur - step;
		end
	endfunction

	lsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (head.colour),
		.den    (dim_divisor),
		.done   (div_done),
		.quo    (div_quo)
	);

	lsf_ram #(
		.Width (lsf_pkg::WordW),
		.Depth (PIXEL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (lsf_pkg::pack_grb(head.colour)),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pix_last = (cnt_q == AddrW'(PIXEL_COUNT - 1));
	assign waddr    = head.idx[AddrW-1:0];
	assign faded    = '{
		red:   fade_chan(current_q.red,   target_q.red,   fade_step),
		green: fade_chan(current_q.green, target_q.green, fade_step),
		blue:  fade_chan(current_q.blue,  target_q.blue,  fade_step)
	};

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lsf_pkg::ST_IDLE: begin
				if (head_valid) begin
					case (head.op)
						lsf_pkg::OP_TARGET: state_nx = lsf_pkg::ST_DIV;
						lsf_pkg::OP_TICK:   state_nx = lsf_pkg::ST_FADE;
						lsf_pkg::OP_CLEAR:  state_nx = lsf_pkg::ST_HDR;
						default:            state_nx = lsf_pkg::ST_IDLE;
					endcase
				end
			end
			lsf_pkg::ST_DIV: begin
				if (div_done) begin
					state_nx = lsf_pkg::ST_FADE;
				end
			end
			lsf_pkg::ST_FADE: state_nx = lsf_pkg::ST_HDR;
			lsf_pkg::ST_HDR:  state_nx = lsf_pkg::ST_PIX;
			lsf_pkg::ST_PIX: begin
				if (pix_last) begin
					state_nx = lsf_pkg::ST_TRL;
				end
			end
			lsf_pkg::ST_TRL:  state_nx = lsf_pkg::ST_IDLE;
			default:          state_nx = lsf_pkg::ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop    = 1'b0;
		div_go = 1'b0;
		mem_we = 1'b0;
		raddr  = '0;
		case (state_q)
			lsf_pkg::ST_IDLE: begin
				pop    = head_valid;
				div_go = head_valid && (head.op == lsf_pkg::OP_TARGET);
				mem_we = head_valid && (head.op == lsf_pkg::OP_PIXEL);
			end
			lsf_pkg::ST_PIX: begin
				if (!pix_last) begin
					raddr = cnt_q + 1'b1;
				end
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// Colour state, fill value and per-entry written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lsf_pkg::ST_IDLE;
			cnt_q     <= '0;
			target_q  <= '0;
			current_q <= '0;
			fill_q    <= '0;
			valid_q   <= '0;
			vsel_s1   <= 1'b0;
		end else begin
			state_q <= state_nx;
			vsel_s1 <= valid_q[raddr];
			if (state_q == lsf_pkg::ST_DIV && div_done) begin
				target_q <= div_quo;
			end
			if (state_q == lsf_pkg::ST_FADE) begin
				current_q <= faded;
				fill_q    <= lsf_pkg::pack_grb(faded);
				valid_q   <= '0;
			end else if (pop && head.op == lsf_pkg::OP_CLEAR) begin
				fill_q  <= lsf_pkg::pack_grb('0);
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (state_q == lsf_pkg::ST_HDR) begin
				cnt_q <= '0;
			end else if (state_q == lsf_pkg::ST_PIX) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Register the frame words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_strobe_q <= 1'b0;
			frame_last_q  <= 1'b0;
		end else begin
			word_strobe_q <= (state_q == lsf_pkg::ST_HDR) ||
				(state_q == lsf_pkg::ST_PIX) || (state_q == lsf_pkg::ST_TRL);
			frame_last_q  <= (state_q == lsf_pkg::ST_TRL);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lsf_pkg::ST_PIX: begin
				shift_word_q <= vsel_s1 ? rdata : fill_q;
				bit_count_q  <= lsf_pkg::PixBits;
			end
			lsf_pkg::ST_TRL: begin
				shift_word_q <= '0;
				bit_count_q  <= lsf_pkg::TrailBits;
			end
			default: begin
				shift_word_q <= '0;
				bit_count_q  <= lsf_pkg::HdrBits;
			end
		endcase
	end

	assign word_strobe = word_strobe_q;
	assign shift_word  = shift_word_q;
	assign bit_count   = bit_count_q;
	assign frame_last  = frame_last_q;

`ifndef SYNTHESIS
	a_trailer_size: assert property (@(posedge clk) disable iff (!arst_n)
		word_strobe_q && frame_last_q |-> bit_count_q == lsf_pkg::TrailBits)
		else $error("trailer word with wrong bit count");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == lsf_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_pixel_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lsf_pkg::ST_PIX |=> word_strobe_q && !frame_last_q)
		else $error("pixel word not strobed");

	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lsf_pkg::ST_TRL |=> state_q == lsf_pkg::ST_IDLE && frame_last_q)
		else $error("frame did not end after trailer");
`endif

endmodule

>>> rtl/led_strip_fade_and_frame_driver.sv
// Before the header word, a tick passes the fade state, a clear goes straight
// to it, and a set-target runs the divider, then fade; a frame is 50 words.
// Tick, set-target and clear each emit a frame, set-pixel only writes the RAM;
// the frame sequencer reading the pixel RAM one word per cycle sets the pace.
// A 2-entry command queue takes start during a frame; the receiver cannot stall.
// Reset clears all colours and marks every pixel as zero; no clearing pass.
// ----------------------------------------------------------------------------
// led_strip_fade_and_frame_driver
// Fading colour engine and frame generator for a serial LED strip.
// ----------------------------------------------------------------------------
module led_strip_fade_and_frame_driver #(
	parameter int PIXEL_COUNT = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [lsf_pkg::IdxW-1:0]      pixel_index,
	input  logic [lsf_pkg::ChanW-1:0]     red,
	input  logic [lsf_pkg::ChanW-1:0]     green,
	input  logic [lsf_pkg::ChanW-1:0]     blue,
	input  logic                          cfg_we,
	input  logic [lsf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lsf_pkg::ChanW-1:0]     cfg_data,
	output logic                          word_strobe,
	output logic [lsf_pkg::WordW-1:0]     shift_word,
	output logic [lsf_pkg::CountW-1:0]    bit_count,
	output logic                          frame_last
);

	logic [lsf_pkg::ChanW-1:0] dim_q;
	logic [lsf_pkg::ChanW-1:0] step_q;
	lsf_pkg::cmd_t             head;
	logic                      head_valid;
	logic                      pop;

	// Configuration registers; a zero divisor is stored as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= 8'd1;
			step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsf_pkg::RegDim:  dim_q  <= (cfg_data == '0) ? 8'd1 : cfg_data;
				lsf_pkg::RegStep: step_q <= cfg_data;
				default:          dim_q  <= dim_q;
			endcase
		end
	end

	lsf_front #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.busy        (busy),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop)
	);

	lsf_back #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.dim_divisor (dim_q),
		.fade_step   (step_q),
		.word_strobe (word_strobe),
		.shift_word  (shift_word),
		.bit_count   (bit_count),
		.frame_last  (frame_last)
	);

endmodule

>>> tb/tb_led_strip_fade_and_frame_driver.sv
// ----------------------------------------------------------------------------
// tb_led_strip_fade_and_frame_driver
// Drives strip commands and register writes into the fade and frame driver,
// predicts every frame word from a local model of the colour engine, and
// compares each strobed word against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_led_strip_fade_and_frame_driver;

	localparam int NumPixels  = 48;
	localparam int SettleCyc  = 200;
	localparam int CycleLimit = 400000;
	localparam int MaxPrinted = 40;

	typedef struct {
		logic [lsf_pkg::WordW-1:0]  word;
		logic [lsf_pkg::CountW-1:0] nbits;
		logic                       last;
	} strip_word_t;

	logic                         clk;
	logic                         arst_n      = 1'b0;
	logic                         start       = 1'b0;
	logic                         busy;
	logic [1:0]                   func        = '0;
	logic [lsf_pkg::IdxW-1:0]     pixel_index = '0;
	logic [lsf_pkg::ChanW-1:0]    red         = '0;
	logic [lsf_pkg::ChanW-1:0]    green       = '0;
	logic [lsf_pkg::ChanW-1:0]    blue        = '0;
	logic                         cfg_we      = 1'b0;
	logic [lsf_pkg::CfgIdxW-1:0]  cfg_index   = '0;
	logic [lsf_pkg::ChanW-1:0]    cfg_data    = '0;
	logic                         word_strobe;
	logic [lsf_pkg::WordW-1:0]    shift_word;
	logic [lsf_pkg::CountW-1:0]   bit_count;
	logic                         frame_last;

	// Local copy of the colour engine state
	logic [lsf_pkg::ChanW-1:0]    dim_div;
	logic [lsf_pkg::ChanW-1:0]    step_size;
	lsf_pkg::rgb_t                target_rgb;
	lsf_pkg::rgb_t                current_rgb;
	logic [lsf_pkg::WordW-1:0]    strip_pixels [NumPixels];

	strip_word_t         frame_words [$];
	int                  err_count  = 0;
	int                  cycle_count = 0;
	bit                  no_idle    = 1'b0;

	led_strip_fade_and_frame_driver #(
		.PIXEL_COUNT(NumPixels)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.word_strobe (word_strobe),
		.shift_word  (shift_word),
		.bit_count   (bit_count),
		.frame_last  (frame_last)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Colour byte triple with the strip mark bit forced on, G-R-B order
	function automatic logic [lsf_pkg::WordW-1:0] strip_grb(input lsf_pkg::rgb_t c);
		logic [lsf_pkg::ChanW-1:0] g;
		logic [lsf_pkg::ChanW-1:0] r;
		logic [lsf_pkg::ChanW-1:0] b;
		g = c.green | lsf_pkg::MarkBit;
		r = c.red | lsf_pkg::MarkBit;
		b = c.blue | lsf_pkg::MarkBit;
		return {g, r, b};
	endfunction

	// Move one channel toward its target, landing on it when close enough
	function automatic logic [lsf_pkg::ChanW-1:0] fade_toward(
		input logic [lsf_pkg::ChanW-1:0] cur,
		input logic [lsf_pkg::ChanW-1:0] tgt);
		logic [lsf_pkg::ChanW-1:0] gap;
		gap = (tgt >= cur) ? tgt - cur : cur - tgt;
		if (step_size == '0 || gap < step_size)
			return tgt;
		if (tgt > cur)
			return cur + step_size;
		return cur - step_size;
	endfunction

	// Queue header, every pixel word and the trailer
	task automatic queue_frame();
		strip_word_t w;
		w.word = '0; w.nbits = lsf_pkg::HdrBits; w.last = 1'b0;
		frame_words.push_back(w);
		for (int i = 0; i < NumPixels; i++) begin
			w.word = strip_pixels[i]; w.nbits = lsf_pkg::PixBits; w.last = 1'b0;
			frame_words.push_back(w);
		end
		w.word = '0; w.nbits = lsf_pkg::TrailBits; w.last = 1'b1;
		frame_words.push_back(w);
	endtask

	// Step the fade, fill the strip with the current colour, emit a frame
	task automatic fade_and_fill();
		current_rgb.red   = fade_toward(current_rgb.red, target_rgb.red);
		current_rgb.green = fade_toward(current_rgb.green, target_rgb.green);
		current_rgb.blue  = fade_toward(current_rgb.blue, target_rgb.blue);
		for (int i = 0; i < NumPixels; i++)
			strip_pixels[i] = strip_grb(current_rgb);
		queue_frame();
	endtask

	// Update the local model for one accepted command
	task automatic predict_command(input lsf_pkg::op_t op,
		input logic [lsf_pkg::IdxW-1:0] idx, input lsf_pkg::rgb_t c);
		case (op)
			lsf_pkg::OP_TARGET: begin
				target_rgb.red   = c.red / dim_div;
				target_rgb.green = c.green / dim_div;
				target_rgb.blue  = c.blue / dim_div;
				fade_and_fill();
			end
			lsf_pkg::OP_TICK: begin
				fade_and_fill();
			end
			lsf_pkg::OP_PIXEL: begin
				if (idx < NumPixels)
					strip_pixels[idx] = strip_grb(c);
			end
			default: begin
				for (int i = 0; i < NumPixels; i++)
					strip_pixels[i] = strip_grb('0);
				queue_frame();
			end
		endcase
	endtask

	task automatic report_mismatch(input string what,
		input logic [lsf_pkg::WordW-1:0] got, input logic [lsf_pkg::WordW-1:0] want);
		if (err_count < MaxPrinted)
			$display("ERROR: %0s got 0x%0h expected 0x%0h at cycle %0d",
				what, got, want, cycle_count);
		err_count++;
	endtask

	// Compare each strobed word with the oldest predicted word
	always @(posedge clk) begin : check_words
		strip_word_t want;
		if (arst_n && word_strobe) begin
			if (frame_words.size() == 0) begin
				report_mismatch("unexpected word", shift_word, '0);
			end else begin
				want = frame_words.pop_front();
				if (shift_word !== want.word)
					report_mismatch("shift_word", shift_word, want.word);
				if (bit_count !== want.nbits)
					report_mismatch("bit_count", lsf_pkg::WordW'(bit_count),
						lsf_pkg::WordW'(want.nbits));
				if (frame_last !== want.last)
					report_mismatch("frame_last", lsf_pkg::WordW'(frame_last),
						lsf_pkg::WordW'(want.last));
			end
		end
	end

	// Send one command transaction; start stays high after acceptance
	task automatic send_cmd(input lsf_pkg::op_t op, input logic [lsf_pkg::IdxW-1:0] idx,
		input lsf_pkg::rgb_t c);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 8));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		func        <= op;
		pixel_index <= idx;
		red         <= c.red;
		green       <= c.green;
		blue        <= c.blue;
		do @(posedge clk); while (busy);
		predict_command(op, idx, c);
	endtask

	// Drop start and wait for every predicted word
	task automatic wait_results();
		start <= 1'b0;
		while (frame_words.size() != 0)
			@(posedge clk);
	endtask

	// Wait until the block is idle, including a trailing set-pixel
	task automatic wait_idle();
		wait_results();
		repeat (SettleCyc) @(posedge clk);
	endtask

	// Write both registers back to back; block must be idle
	task automatic set_fade_config(input logic [lsf_pkg::ChanW-1:0] dim,
		input logic [lsf_pkg::ChanW-1:0] stp);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= lsf_pkg::RegDim;
		cfg_data  <= dim;
		@(posedge clk);
		cfg_index <= lsf_pkg::RegStep;
		cfg_data  <= stp;
		@(posedge clk);
		cfg_we    <= 1'b0;
		dim_div   = (dim == '0) ? 8'd1 : dim;
		step_size = stp;
	endtask

	function automatic lsf_pkg::rgb_t make_rgb(input int r, input int g, input int b);
		lsf_pkg::rgb_t c;
		c.red   = lsf_pkg::ChanW'(r);
		c.green = lsf_pkg::ChanW'(g);
		c.blue  = lsf_pkg::ChanW'(b);
		return c;
	endfunction

	// Clear fills the strip with marked zeros; a tick after reset does too
	task automatic test_clear_frame();
		send_cmd(lsf_pkg::OP_CLEAR, 6'd0, make_rgb(0, 0, 0));
		send_cmd(lsf_pkg::OP_TICK, 6'd63, make_rgb(255, 255, 255));
	endtask

	// Pixel writes at both ends of the strip and beyond it, then a clear
	task automatic test_set_pixel_bounds();
		send_cmd(lsf_pkg::OP_PIXEL, 6'd0, make_rgb(0, 0, 0));
		send_cmd(lsf_pkg::OP_PIXEL, 6'd47, make_rgb(255, 255, 255));
		send_cmd(lsf_pkg::OP_PIXEL, 6'd48, make_rgb(18, 52, 86));
		send_cmd(lsf_pkg::OP_PIXEL, 6'd63, make_rgb(127, 128, 1));
		send_cmd(lsf_pkg::OP_CLEAR, 6'd21, make_rgb(170, 85, 170));
	endtask

	// Target division at divisor zero (taken as one), 255 and 3
	task automatic test_target_dim();
		set_fade_config(8'd0, 8'd0);
		send_cmd(lsf_pkg::OP_TARGET, 6'd42, make_rgb(255, 255, 255));
		set_fade_config(8'd255, 8'd0);
		send_cmd(lsf_pkg::OP_TARGET, 6'd0, make_rgb(255, 254, 1));
		set_fade_config(8'd3, 8'd0);
		send_cmd(lsf_pkg::OP_TARGET, 6'd0, make_rgb(200, 100, 7));
		send_cmd(lsf_pkg::OP_TARGET, 6'd0, make_rgb(0, 0, 0));
	endtask

	// Gradual fades, a full-range step, and a gap smaller than the step
	task automatic test_fade_steps();
		set_fade_config(8'd1, 8'd16);
		send_cmd(lsf_pkg::OP_TARGET, 6'd0, make_rgb(255, 0, 128));
		send_cmd(lsf_pkg::OP_TICK, 6'd0, make_rgb(0, 0, 0));
		send_cmd(lsf_pkg::OP_TICK, 6'd0, make_rgb(0, 0, 0));
		set_fade_config(8'd1, 8'd255);
		send_cmd(lsf_pkg::OP_TICK, 6'd0, make_rgb(0, 0, 0));
		send_cmd(lsf_pkg::OP_TARGET, 6'd0, make_rgb(0, 255, 0));
		set_fade_config(8'd1, 8'd1);
		send_cmd(lsf_pkg::OP_TARGET, 6'd0, make_rgb(1, 254, 2));
		send_cmd(lsf_pkg::OP_TICK, 6'd0, make_rgb(0, 0, 0));
	endtask

	// Random command streams across several register settings
	task automatic test_random_traffic();
		lsf_pkg::rgb_t c;
		lsf_pkg::op_t  op;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_fade_config(lsf_pkg::ChanW'($urandom_range(0, 255)),
					lsf_pkg::ChanW'($urandom_range(0, 255)));
				1: set_fade_config(8'd255, 8'd255);
				2: set_fade_config(8'd1, 8'd0);
				default: set_fade_config(lsf_pkg::ChanW'($urandom_range(0, 4)),
					lsf_pkg::ChanW'($urandom_range(1, 8)));
			endcase
			no_idle = (phase == 1);
			for (int n = 0; n < 50; n++) begin
				if (phase == 2 && n == 25)
					wait_results();
				op = lsf_pkg::op_t'($urandom_range(0, 3));
				c  = make_rgb(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
					int'($urandom_range(0, 255)));
				send_cmd(op, lsf_pkg::IdxW'($urandom_range(0, 63)), c);
			end
			no_idle = 1'b0;
		end
	endtask

	// Test sequence
	initial begin
		dim_div     = 8'd1;
		step_size   = 8'd0;
		target_rgb  = '0;
		current_rgb = '0;
		for (int i = 0; i < NumPixels; i++)
			strip_pixels[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clear_frame();
		test_set_pixel_bounds();
		test_target_dim();
		test_fade_steps();
		test_random_traffic();

		wait_idle();
		if (err_count == 0 && frame_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
